/* hdl/cpsa_pkg.sv */
// Shared constants for the capture period speed averager.
// No dependencies; used by the top level capture_period_speed_averager.
`default_nettype none

package cpsa_pkg;

    localparam int CLOCK_W    = 24;   // clock_hz register width
    localparam int PRESCALE_W = 4;    // prescale_log2 register width
    localparam int CAPTURE_W  = 16;   // capture_time field width
    localparam int SPEED_W    = 32;   // speed and average width, Q24.8
    localparam int FRAC_W     = 8;    // fraction bits of the speed
    localparam int PRESCALE_MAX_SHIFT = (1 << PRESCALE_W) - 1;

    localparam int AVG_DEPTH_DEFAULT   = 16;
    localparam int TIMER_WIDTH_DEFAULT = 16;

    localparam logic [CLOCK_W-1:0]    CLOCK_HZ_RESET = 24'd10000000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 4'd8;
    localparam logic [SPEED_W-1:0]    SPEED_MAX      = '1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_HZ = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE = 1'd1;

endpackage

`default_nettype wire

/* hdl/cpsa_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing; shared by the speed and average paths of the top level.
`default_nettype none

module cpsa_divider #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 31
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;    // dividend shifts out, quotient in
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {rem_reg, quot_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quot_next = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* hdl/cpsa_ring_mem.sv */
// Speed ring: synchronous RAM with registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none

module cpsa_ring_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* hdl/capture_period_speed_averager.sv */
// Capture period tachometer with moving-average speed: top level.
// Depends on cpsa_pkg, cpsa_divider and cpsa_ring_mem.
//
// Usage:
//   s_ channel: one capture timestamp per item. The wrapping difference to
//   the previous timestamp (zero after reset) sets the period, and
//   speed_q8 = (clock_hz << 8) / (difference << prescale_log2), Q24.8.
//   A zero difference gives the all-ones speed and sets zero_interval.
//   m_ channel: one result item per input item carrying the speed, the mean
//   of the last AVG_DEPTH speeds (the new one included) and the flag.
//   cfg_ port: plain write port; the user must write it only while the
//   block is idle, the block itself does not enforce this.
// Sequencing:
//   An accepted item passes the ring read, the bit-serial divider when the
//   difference is nonzero (NUM_W = max(32, 32 + log2(AVG_DEPTH)), 36 at the
//   default depth), the sum update and the output wait; a zero difference
//   skips the divider. A non-power-of-two AVG_DEPTH adds a second divider
//   pass for the mean. One item is in work at a time: s_tready is high only
//   while the sequencer is idle; it returns there once the result is loaded.
// Reset: synchronous, active low. Config registers return to their defaults,
//   previous capture, ring index and running sum clear, all ring entries
//   read as zero through their valid bits. No clearing pass is needed.
// Stall: the result sits in the output register; the next item is accepted
//   and worked on meanwhile and waits before the output register if needed.
`default_nettype none

module capture_period_speed_averager #(
    parameter int AVG_DEPTH   = cpsa_pkg::AVG_DEPTH_DEFAULT,
    parameter int TIMER_WIDTH = cpsa_pkg::TIMER_WIDTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] capture_time
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,    // [31:0] speed_q8, [63:32] average_q8
    output logic      [0:0]  m_tuser,    // [0] zero_interval
    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [cpsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cpsa_pkg::CLOCK_W-1:0]       cfg_wdata
);

    localparam int SPEED_W = cpsa_pkg::SPEED_W;
    localparam int IDX_W   = $clog2(AVG_DEPTH);
    localparam int SUM_W   = SPEED_W + IDX_W;
    localparam int NUM_W   = (SUM_W > SPEED_W) ? SUM_W : SPEED_W;
    localparam int PDEN_W  = TIMER_WIDTH + cpsa_pkg::PRESCALE_MAX_SHIFT;
    localparam int ADEN_W  = $clog2(AVG_DEPTH + 1);
    localparam int DEN_W   = (PDEN_W > ADEN_W) ? PDEN_W : ADEN_W;
    localparam bit AVG_POW2 = (AVG_DEPTH & (AVG_DEPTH - 1)) == 0;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;   // old ring entry arrives
    localparam logic [2:0] ST_DIV  = 3'd2;   // speed division running
    localparam logic [2:0] ST_SUM  = 3'd3;   // update sum, write ring
    localparam logic [2:0] ST_AVG  = 3'd4;   // mean division running
    localparam logic [2:0] ST_OUT  = 3'd5;   // wait for output register

    logic [2:0] state_reg, state_next;

    logic [cpsa_pkg::CLOCK_W-1:0]    clock_hz_reg;
    logic [cpsa_pkg::PRESCALE_W-1:0] prescale_reg;

    logic [TIMER_WIDTH-1:0] prev_reg, prev_next;
    logic [TIMER_WIDTH-1:0] diff_reg, diff_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [SPEED_W-1:0]     old_reg, old_next;
    logic [SPEED_W-1:0]     avg_reg, avg_next;
    logic                   zero_reg, zero_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [63:0]            m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic                   accept;
    logic [TIMER_WIDTH-1:0] now_c;
    logic [SUM_W-1:0]       sum_upd_c;
    logic                   out_free;

    logic                   div_start;
    logic [NUM_W-1:0]       div_dividend;
    logic [DEN_W-1:0]       div_divisor;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quotient;

    logic                   ring_wr_en;
    logic                   ring_rd_en;
    logic [SPEED_W-1:0]     ring_rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign now_c    = TIMER_WIDTH'(s_tdata);
    assign out_free = !m_tvalid_reg || m_tready;

    // running sum drops the overwritten entry and adds the new speed
    assign sum_upd_c = sum_reg - SUM_W'(old_reg) + SUM_W'(speed_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= cpsa_pkg::CLOCK_HZ_RESET;
            prescale_reg <= cpsa_pkg::PRESCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cpsa_pkg::REG_CLOCK_HZ: clock_hz_reg <= cfg_wdata;
                cpsa_pkg::REG_PRESCALE: prescale_reg <= cfg_wdata[cpsa_pkg::PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        prev_next     = prev_reg;
        diff_next     = diff_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        speed_next    = speed_reg;
        old_next      = old_reg;
        avg_next      = avg_reg;
        zero_next     = zero_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_start     = 1'b0;
        div_dividend  = NUM_W'({clock_hz_reg, {cpsa_pkg::FRAC_W{1'b0}}});
        div_divisor   = DEN_W'(diff_reg) << prescale_reg;
        ring_wr_en    = 1'b0;
        ring_rd_en    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // fetch the entry this item overwrites
                    ring_rd_en = 1'b1;
                    prev_next  = now_c;
                    diff_next  = now_c - prev_reg;
                    zero_next  = (now_c == prev_reg);
                    speed_next = cpsa_pkg::SPEED_MAX;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                old_next = ring_rd_data;
                if (zero_reg) begin
                    state_next = ST_SUM;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    speed_next = div_quotient[SPEED_W-1:0];
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                ring_wr_en = 1'b1;
                sum_next   = sum_upd_c;
                idx_next   = (idx_reg == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_reg + IDX_W'(1);
                if (AVG_POW2) begin
                    avg_next   = SPEED_W'(sum_upd_c >> IDX_W);
                    state_next = ST_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = NUM_W'(sum_upd_c);
                    div_divisor  = DEN_W'(AVG_DEPTH);
                    state_next   = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    avg_next   = div_quotient[SPEED_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {avg_reg, speed_reg};
                    m_tuser_next  = zero_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prev_reg     <= prev_next;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        diff_reg    <= diff_next;
        speed_reg   <= speed_next;
        old_reg     <= old_next;
        avg_reg     <= avg_next;
        zero_reg    <= zero_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    cpsa_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    cpsa_ring_mem #(
        .DEPTH (AVG_DEPTH),
        .WIDTH (SPEED_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ring_wr_en),
        .wr_addr (idx_reg),
        .wr_data (speed_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ring_rd_data)
    );

    // divider finishes only while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV || state_reg == ST_AVG))
        else $error("divider done outside a division state");

    // an accepted item always moves to the ring read
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_READ))
        else $error("accepted item did not start the ring read");

    // a zero interval result carries the saturated speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == cpsa_pkg::SPEED_MAX))
        else $error("zero interval without saturated speed");

    // a new result appears only from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_next && !(m_tvalid_reg && !m_tready)) |-> (state_reg == ST_OUT))
        else $error("result loaded outside the output state");

endmodule

`default_nettype wire
